// ----- sv/tlnc_pkg.sv -----
package tlnc_pkg;

    // Input word: one raw text byte plus the start-of-file mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } in_word_t;

    // Output word: one rendered byte, last marks the final byte of an item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_word_t;

    // Configuration register set
    typedef struct packed {
        logic [1:0] number_mode;
        logic       merge_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_ctrl;
    } cfg_t;

    // Per-line tracking state carried between bytes
    typedef struct packed {
        logic at_line_start;
        logic squeezing;
    } line_state_t;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_BLANK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CTRL   = 3'd4;
    localparam int CFG_DATA_W = 2;

    // Longest rendering of one text byte, without the line number ("M-^X")
    localparam int BODY_MAX   = 4;
    localparam int BODY_LEN_W = 3;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_QMARK  = 8'h3F;
    localparam logic [7:0] CHAR_I      = 8'h49;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;
    localparam logic [6:0] LOW_DEL     = 7'd127;
    localparam logic [6:0] LOW_SPACE   = 7'd32;
    localparam logic [3:0] BCD_NINE    = 4'd9;

endpackage

// ----- sv/tlnc_count.sv -----
module tlnc_count #(
    parameter int LINE_DIGITS = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     bump,
    output logic [LINE_DIGITS*4-1:0] digits
);
    import tlnc_pkg::*;

    localparam int COUNT_W = LINE_DIGITS * 4;

    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic [LINE_DIGITS:0]   carry;
    logic [LINE_DIGITS-1:0] nines;

    // BCD increment: a digit rolls when every digit below it is nine
    assign carry[0] = 1'b1;
    for (genvar i = 0; i < LINE_DIGITS; i++) begin : g_digit
        assign nines[i]     = (count_reg[4*i +: 4] == BCD_NINE);
        assign carry[i + 1] = carry[i] & nines[i];
        assign count_next[4*i +: 4] = !carry[i] ? count_reg[4*i +: 4] :
                                      nines[i]  ? 4'd0 :
                                                  count_reg[4*i +: 4] + 4'd1;
    end

    // carry out of the top digit means all nines: hold there
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
        end
        else if (bump && !carry[LINE_DIGITS])
        begin
            count_reg <= count_next;
        end
    end

    assign digits = count_reg;

endmodule

// ----- sv/tlnc_expand.sv -----
module tlnc_expand #(
    parameter int LINE_DIGITS = 6,
    localparam int PLAN_BYTES = LINE_DIGITS + 1 + tlnc_pkg::BODY_MAX,
    localparam int LEN_W      = $clog2(PLAN_BYTES + 1)
) (
    input  tlnc_pkg::in_word_t         in_word,
    input  tlnc_pkg::cfg_t             cfg,
    input  tlnc_pkg::line_state_t      state,
    input  logic [LINE_DIGITS*4-1:0]   digits,
    output logic [PLAN_BYTES-1:0][7:0] plan,
    output logic [LEN_W-1:0]           plan_len,
    output tlnc_pkg::line_state_t      state_next,
    output logic                       bump
);
    import tlnc_pkg::*;

    logic [7:0]               ch;
    logic                     nl;
    logic                     ls;
    logic                     sq;
    logic                     drop;
    logic                     num;
    logic [6:0]               low;
    logic [7:0]               tail0;
    logic [7:0]               tail1;
    logic [1:0]               tail_len;
    logic [BODY_MAX-1:0][7:0] body;
    logic [BODY_LEN_W-1:0]    body_len;
    logic [LINE_DIGITS:0]     lead;
    logic [LINE_DIGITS-1:0][7:0] num_char;

    always_comb
    begin
        ch   = in_word.in_byte;
        nl   = (ch == CHAR_NL);
        ls   = in_word.file_start | state.at_line_start;
        sq   = !in_word.file_start & state.squeezing;
        drop = nl & ls & cfg.merge_blank & sq;
        // mode bit 1 (non-blank only) wins over bit 0
        num  = !drop & ls & (cfg.number_mode[1] ? !nl : cfg.number_mode[0]);
        low  = ch[6:0];

        // caret rendering of the low seven bits
        if (low < LOW_SPACE)
        begin
            tail0    = CHAR_CARET;
            tail1    = {1'b0, low} + CTRL_OFFSET;
            tail_len = 2'd2;
        end
        else if (low == LOW_DEL)
        begin
            tail0    = CHAR_CARET;
            tail1    = CHAR_QMARK;
            tail_len = 2'd2;
        end
        else
        begin
            tail0    = {1'b0, low};
            tail1    = CHAR_SPACE;
            tail_len = 2'd1;
        end

        body       = '0;
        body_len   = '0;
        state_next = state;
        if (drop)
        begin
            state_next.at_line_start = 1'b1;
            state_next.squeezing     = 1'b1;
        end
        else if (nl)
        begin
            state_next.at_line_start = 1'b1;
            state_next.squeezing     = (ls & cfg.merge_blank) | sq;
            if (cfg.show_ends)
            begin
                body[0]  = CHAR_DOLLAR;
                body[1]  = CHAR_NL;
                body_len = 3'd2;
            end
            else
            begin
                body[0]  = CHAR_NL;
                body_len = 3'd1;
            end
        end
        else
        begin
            state_next.at_line_start = 1'b0;
            state_next.squeezing     = 1'b0;
            if (ch == CHAR_TAB)
            begin
                if (cfg.show_tabs)
                begin
                    body[0]  = CHAR_CARET;
                    body[1]  = CHAR_I;
                    body_len = 3'd2;
                end
                else
                begin
                    body[0]  = CHAR_TAB;
                    body_len = 3'd1;
                end
            end
            else if (!cfg.show_ctrl)
            begin
                body[0]  = ch;
                body_len = 3'd1;
            end
            else if (ch[7])
            begin
                body[0]  = CHAR_M;
                body[1]  = CHAR_DASH;
                body[2]  = tail0;
                body[3]  = tail1;
                body_len = 3'd2 + {1'b0, tail_len};
            end
            else
            begin
                body[0]  = tail0;
                body[1]  = tail1;
                body_len = {1'b0, tail_len};
            end
        end
    end

    // leading zeros print as spaces, the units digit always prints
    assign lead[LINE_DIGITS] = 1'b1;
    for (genvar i = 0; i < LINE_DIGITS; i++) begin : g_num
        if (i == 0) begin : g_units
            assign lead[i] = 1'b0;
        end
        else begin : g_upper
            assign lead[i] = lead[i + 1] & (digits[4*i +: 4] == 4'd0);
        end
        assign num_char[i] = lead[i] ? CHAR_SPACE : CHAR_ZERO + {4'd0, digits[4*i +: 4]};
    end

    // plan layout: number (most significant first), tab, then body; with no number the body starts at byte 0
    for (genvar k = 0; k < PLAN_BYTES; k++) begin : g_plan
        logic [7:0] plain;
        if (k < BODY_MAX) begin : g_body
            assign plain = body[k];
        end
        else begin : g_pad
            assign plain = 8'h00;
        end
        if (k < LINE_DIGITS) begin : g_dig
            assign plan[k] = num ? num_char[LINE_DIGITS-1-k] : plain;
        end
        else if (k == LINE_DIGITS) begin : g_tab
            assign plan[k] = num ? CHAR_TAB : plain;
        end
        else begin : g_tail
            assign plan[k] = num ? body[k-LINE_DIGITS-1] : plain;
        end
    end

    assign plan_len = (num ? LEN_W'(LINE_DIGITS + 1) : LEN_W'(0)) + LEN_W'(body_len);
    assign bump     = num;

endmodule

// ----- sv/tlnc_drain.sv -----
module tlnc_drain #(
    parameter int LINE_DIGITS = 6,
    localparam int PLAN_BYTES = LINE_DIGITS + 1 + tlnc_pkg::BODY_MAX,
    localparam int LEN_W      = $clog2(PLAN_BYTES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [PLAN_BYTES-1:0][7:0] plan,
    input  logic [LEN_W-1:0]           plan_len,
    output logic                       plan_free,
    output logic                       out_valid,
    input  logic                       out_stall,
    output tlnc_pkg::out_word_t        out_data
);
    import tlnc_pkg::*;

    logic [PLAN_BYTES-1:0][7:0] plan_reg;
    logic [LEN_W-1:0]           left_reg;
    logic                       out_valid_reg;
    out_word_t                  out_data_reg;
    logic                       out_load;
    logic                       take;

    assign out_load  = !out_valid_reg || !out_stall;
    assign take      = out_load && (left_reg != '0);
    assign plan_free = (left_reg == '0) || ((left_reg == LEN_W'(1)) && out_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                left_reg <= plan_len;
            end
            else if (take)
            begin
                left_reg <= left_reg - LEN_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= (left_reg != '0);
            end
        end
    end

    // byte 0 is always the next one out; the rest shift down
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan;
        end
        else if (take)
        begin
            plan_reg[PLAN_BYTES-1] <= 8'h00;
            for (int k = 0; k < PLAN_BYTES - 1; k++)
            begin
                plan_reg[k] <= plan_reg[k + 1];
            end
        end
        if (take)
        begin
            out_data_reg.out_byte <= plan_reg[0];
            out_data_reg.last     <= (left_reg == LEN_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_load_only_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (left_reg == '0) || ((left_reg == LEN_W'(1)) && out_load))
        else $error("plan overwritten while bytes remain");

    a_left_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= LEN_W'(PLAN_BYTES))
        else $error("byte count out of range");

    a_last_on_final : assert property (@(posedge clk) disable iff (!rst_n)
        (take && (left_reg == LEN_W'(1))) |=> out_valid_reg && out_data_reg.last)
        else $error("final byte not marked last");

    a_not_last_mid : assert property (@(posedge clk) disable iff (!rst_n)
        (take && (left_reg > LEN_W'(1))) |=> out_valid_reg && !out_data_reg.last)
        else $error("last marked before final byte");

endmodule

// ----- sv/text_line_number_caret_filter.sv -----
// An accepted word passes through the plan register, then the output register.
// Throughput: one input word per cycle while each yields one output word and the
// output does not stall; a word that expands to N output words (N up to
// LINE_DIGITS + 5) holds the plan shifter until all N are out, and a dropped
// blank line is accepted but yields no output word.
// Reset (async, active low): config cleared, at line start, line counter = 1.
module text_line_number_caret_filter #(
    parameter int LINE_DIGITS = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input byte channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  tlnc_pkg::in_word_t                   in_data,
    // rendered byte channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output tlnc_pkg::out_word_t                  out_data,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlnc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlnc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tlnc_pkg::*;

    localparam int PLAN_BYTES = LINE_DIGITS + 1 + BODY_MAX;
    localparam int LEN_W      = $clog2(PLAN_BYTES + 1);

    cfg_t                       cfg_reg;
    line_state_t                state_reg;
    line_state_t                state_next;
    logic [LINE_DIGITS*4-1:0]   digits;
    logic [PLAN_BYTES-1:0][7:0] plan;
    logic [LEN_W-1:0]           plan_len;
    logic                       bump;
    logic                       plan_free;
    logic                       accept;

    // Register writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NUMBER_MODE: cfg_reg.number_mode <= cfg_data;
                CFG_MERGE_BLANK: cfg_reg.merge_blank <= cfg_data[0];
                CFG_SHOW_ENDS:   cfg_reg.show_ends   <= cfg_data[0];
                CFG_SHOW_TABS:   cfg_reg.show_tabs   <= cfg_data[0];
                CFG_SHOW_CTRL:   cfg_reg.show_ctrl   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // A new word is taken whenever the plan shifter empties this cycle,
    // so the output register can still hold a stalled word meanwhile.
    assign in_stall = !plan_free;
    assign accept   = in_valid && plan_free;

    // Line tracking advances as each word is accepted; the expander sees
    // the state left by the word before it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.at_line_start <= 1'b1;
            state_reg.squeezing     <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // BCD line counter, saturating at all nines
    tlnc_count #(
        .LINE_DIGITS(LINE_DIGITS)
    ) u_count (
        .clk    (clk),
        .rst_n  (rst_n),
        .bump   (accept && bump),
        .digits (digits)
    );

    // Turns one input byte into its full output byte string
    tlnc_expand #(
        .LINE_DIGITS(LINE_DIGITS)
    ) u_expand (
        .in_word    (in_data),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .digits     (digits),
        .plan       (plan),
        .plan_len   (plan_len),
        .state_next (state_next),
        .bump       (bump)
    );

    // Holds the byte string and feeds it out one word per cycle while the output is not stalled
    tlnc_drain #(
        .LINE_DIGITS(LINE_DIGITS)
    ) u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .plan      (plan),
        .plan_len  (plan_len),
        .plan_free (plan_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_drop_keeps_line_start : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && plan_len == '0) |=> state_reg.at_line_start && state_reg.squeezing)
        else $error("dropped newline left line start");

    a_squeeze_needs_line_start : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.squeezing |-> state_reg.at_line_start)
        else $error("squeezing set away from line start");

    a_bump_at_line_start : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bump) |-> (state_reg.at_line_start || in_data.file_start))
        else $error("line number emitted mid-line");

endmodule

// ----- tb/sv/text_line_number_caret_filter_tb.sv -----
`timescale 1ns / 1ps

module text_line_number_caret_filter_tb;

    import tlnc_pkg::*;

    // Counter width of the block under test (its default)
    localparam int DIGITS       = 6;
    // Idle padding after the last owed word, so the pipe can go quiet
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 16;
    localparam int SEGMENTS     = 10;
    localparam int SEG_WORDS    = 41;
    // Timeout in ns at a 2 ns clock; a correct run needs a few percent of it
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int REPORT_MAX   = 10;

    // Indexes past the register file: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    text_line_number_caret_filter #(
        .LINE_DIGITS(DIGITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Renderer model: its own copy of the registers and line state
    // ------------------------------------------------------------------
    cfg_t                  pred_cfg;
    logic                  pred_line_start;
    logic                  pred_squeezing;
    logic [4*DIGITS-1:0]   pred_line_bcd;

    out_word_t             fresh_q[$];     // words rendered for the latest byte
    out_word_t             rendered_q[$];  // words still owed by the block

    int                    fail_count;
    int                    words_checked;
    int                    bytes_sent;
    int                    settings_used;
    int                    send_gap_pct;
    int                    recv_stall_pct;

    function automatic void put_byte(input logic [7:0] b);
        out_word_t w;
        w.out_byte = b;
        w.last     = 1'b0;
        fresh_q.push_back(w);
    endfunction

    // Render one text byte into fresh_q and advance the line state
    task automatic render_byte(input in_word_t w);
        logic [7:0] ch;
        logic [7:0] low;
        logic [3:0] digit;
        logic       number_it;
        logic       lead;
        logic       all_nines;
        logic       carry;
        fresh_q.delete();
        ch = w.in_byte;
        if (w.file_start)
        begin
            pred_line_start = 1'b1;
            pred_squeezing  = 1'b0;
        end
        // another blank line inside a squeezed run vanishes entirely
        if (ch == CHAR_NL && pred_line_start && pred_cfg.merge_blank && pred_squeezing)
            return;
        if (pred_line_start)
        begin
            // non-blank mode wins when both mode bits are set
            if (pred_cfg.number_mode[1])
                number_it = (ch != CHAR_NL);
            else
                number_it = pred_cfg.number_mode[0];
            if (number_it)
            begin
                lead = 1'b1;
                for (int i = DIGITS - 1; i >= 0; i--)
                begin
                    digit = pred_line_bcd[4*i +: 4];
                    if (digit != 4'd0 || i == 0)
                        lead = 1'b0;
                    put_byte(lead ? CHAR_SPACE : 8'(CHAR_ZERO + digit));
                end
                put_byte(CHAR_TAB);
                // BCD increment, sticking at all nines
                all_nines = 1'b1;
                for (int i = 0; i < DIGITS; i++)
                    if (pred_line_bcd[4*i +: 4] != BCD_NINE)
                        all_nines = 1'b0;
                if (!all_nines)
                begin
                    carry = 1'b1;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        if (carry)
                        begin
                            if (pred_line_bcd[4*i +: 4] == BCD_NINE)
                                pred_line_bcd[4*i +: 4] = 4'd0;
                            else
                            begin
                                pred_line_bcd[4*i +: 4] = pred_line_bcd[4*i +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
            end
        end
        if (ch == CHAR_NL)
        begin
            if (pred_line_start && pred_cfg.merge_blank)
                pred_squeezing = 1'b1;
            if (pred_cfg.show_ends)
                put_byte(CHAR_DOLLAR);
            put_byte(CHAR_NL);
            pred_line_start = 1'b1;
        end
        else
        begin
            pred_squeezing  = 1'b0;
            pred_line_start = 1'b0;
            if (ch == CHAR_TAB)
            begin
                // tab stays raw unless show_tabs, even with show_ctrl
                if (pred_cfg.show_tabs)
                begin
                    put_byte(CHAR_CARET);
                    put_byte(CHAR_I);
                end
                else
                    put_byte(CHAR_TAB);
            end
            else if (!pred_cfg.show_ctrl)
                put_byte(ch);
            else
            begin
                low = ch;
                if (ch[7])
                begin
                    put_byte(CHAR_M);
                    put_byte(CHAR_DASH);
                    low = {1'b0, ch[6:0]};
                end
                if (low < 8'(LOW_SPACE))
                begin
                    put_byte(CHAR_CARET);
                    put_byte(8'(low + CTRL_OFFSET));
                end
                else if (low[6:0] == LOW_DEL)
                begin
                    put_byte(CHAR_CARET);
                    put_byte(CHAR_QMARK);
                end
                else
                    put_byte(low);
            end
        end
        fresh_q[fresh_q.size() - 1].last = 1'b1;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Drivers; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------

    // Offer one text byte, hold it until taken, then queue what it owes.
    // A row with a typed rendering queues that instead of the model's.
    task automatic send_word(input in_word_t w, input bit typed, input string text);
        out_word_t t;
        // idle cycle by cycle so the idle share matches the percentage
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        render_byte(w);
        if (typed)
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                t.out_byte = text[i];
                t.last     = (i == text.len() - 1);
                rendered_q.push_back(t);
            end
        end
        else
        begin
            foreach (fresh_q[i])
                rendered_q.push_back(fresh_q[i]);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Stop sending, let every owed word arrive and the pipe go quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rendered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NUMBER_MODE: pred_cfg.number_mode = val;
            CFG_MERGE_BLANK: pred_cfg.merge_blank = val[0];
            CFG_SHOW_ENDS:   pred_cfg.show_ends   = val[0];
            CFG_SHOW_TABS:   pred_cfg.show_tabs   = val[0];
            CFG_SHOW_CTRL:   pred_cfg.show_ctrl   = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly text lines with blank runs, plus control, DEL and high bytes
    function automatic in_word_t pick_text_byte();
        in_word_t w;
        int       r;
        r = $urandom_range(99);
        if (r < 18)
            w.in_byte = CHAR_NL;
        else if (r < 28)
            w.in_byte = CHAR_TAB;
        else if (r < 58)
            w.in_byte = 8'($urandom_range(32, 126));
        else if (r < 70)
            w.in_byte = 8'($urandom_range(0, 31));
        else if (r < 75)
            w.in_byte = {1'b0, LOW_DEL};
        else
            w.in_byte = 8'($urandom_range(128, 255));
        w.file_start = ($urandom_range(99) < 3);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Directed table: register rows and byte rows, walked in order
    // ------------------------------------------------------------------
    bit                dir_is_reg[$];
    logic [7:0]        dir_a[$];      // byte, or register index
    logic [1:0]        dir_b[$];      // file_start, or register data
    bit                dir_typed[$];
    string             dir_text[$];

    task automatic row_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
        dir_is_reg.push_back(1'b1);
        dir_a.push_back(8'(idx));
        dir_b.push_back(val);
        dir_typed.push_back(1'b0);
        dir_text.push_back("");
    endtask

    task automatic row_byte(input logic [7:0] b, input logic fs, input bit typed,
                            input string text);
        dir_is_reg.push_back(1'b0);
        dir_a.push_back(b);
        dir_b.push_back({1'b0, fs});
        dir_typed.push_back(typed);
        dir_text.push_back(text);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, then check each taken word in order
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

    out_word_t due;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rendered_q.size() == 0)
                note_failure($sformatf("unexpected word: byte %02h last %0b",
                                       out_data.out_byte, out_data.last));
            else
            begin
                due = rendered_q.pop_front();
                if (out_data.out_byte !== due.out_byte || out_data.last !== due.last)
                    note_failure($sformatf(
                        "mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        due.out_byte, due.last, out_data.out_byte, out_data.last));
                words_checked++;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d words still owed", rendered_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    in_word_t stim;

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        pred_cfg        = '0;
        pred_line_start = 1'b1;
        pred_squeezing  = 1'b0;
        pred_line_bcd   = (4*DIGITS)'(1);
        fail_count      = 0;
        words_checked   = 0;
        bytes_sent      = 0;
        settings_used   = 1;
        send_gap_pct    = 21;
        recv_stall_pct  = 64;

        // Reset state: plain pass-through
        row_byte("A", 1'b0, 1, "A");
        row_byte(8'h00, 1'b0, 0, "");
        row_byte(8'hFF, 1'b0, 0, "");
        row_byte(CHAR_NL, 1'b0, 1, "\n");
        // Everything on, plus writes to unused indexes that must be ignored
        row_reg(CFG_NUMBER_MODE, 2'd1);
        row_reg(CFG_MERGE_BLANK, 2'd1);
        row_reg(CFG_SHOW_ENDS, 2'd1);
        row_reg(CFG_SHOW_TABS, 2'd1);
        row_reg(CFG_SHOW_CTRL, 2'd1);
        row_reg(CFG_IDX_SPARE_LO, 2'd3);
        row_reg(CFG_IDX_SPARE_HI, 2'd0);
        row_byte("x", 1'b0, 1, "     1\tx");
        row_byte(CHAR_TAB, 1'b0, 1, "^I");
        row_byte(8'h81, 1'b0, 1, "M-^A");
        row_byte(8'hFF, 1'b0, 1, "M-^?");
        row_byte(8'h7F, 1'b0, 1, "^?");
        row_byte(8'hA0, 1'b0, 1, "M- ");
        row_byte(CHAR_NL, 1'b0, 1, "$\n");
        row_byte(CHAR_NL, 1'b0, 1, "     2\t$\n");
        // squeezed blank line: nothing comes out
        row_byte(CHAR_NL, 1'b0, 1, "");
        // file start ends the squeeze run
        row_byte(CHAR_NL, 1'b1, 1, "     3\t$\n");
        // Non-blank numbering; tab raw with only control rendering on
        row_reg(CFG_NUMBER_MODE, 2'd2);
        row_reg(CFG_SHOW_TABS, 2'd0);
        row_byte(CHAR_NL, 1'b1, 1, "$\n");
        row_byte(CHAR_TAB, 1'b0, 1, "     4\t\t");
        row_byte(8'h1B, 1'b0, 1, "^[");
        // Both mode bits set: acts as non-blank numbering
        row_reg(CFG_NUMBER_MODE, 2'd3);
        row_reg(CFG_SHOW_CTRL, 2'd0);
        row_byte(CHAR_NL, 1'b0, 1, "$\n");
        row_byte(CHAR_NL, 1'b0, 1, "$\n");
        row_byte(8'hC1, 1'b0, 0, "");
        row_byte("q", 1'b0, 1, "q");

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < dir_is_reg.size(); r++)
        begin
            if (dir_is_reg[r])
            begin
                // only drain when coming off a byte row
                if (r == 0 || !dir_is_reg[r-1])
                begin
                    wait_drained();
                    settings_used++;
                end
                write_reg(dir_a[r][CFG_IDX_W-1:0], dir_b[r]);
            end
            else
            begin
                stim.in_byte    = dir_a[r];
                stim.file_start = dir_b[r][0];
                send_word(stim, dir_typed[r], dir_text[r]);
            end
        end

        // Random segments, each under fresh register settings.
        // Idle mix: sender-light first, then receiver-light, then none.
        for (int s = 0; s < SEGMENTS; s++)
        begin
            wait_drained();
            if (s < 4)
            begin
                send_gap_pct   = 21;
                recv_stall_pct = 64;
            end
            else if (s < 7)
            begin
                send_gap_pct   = 64;
                recv_stall_pct = 21;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            // first segment all bits set, second all clear, rest random
            write_reg(CFG_NUMBER_MODE,
                      s == 0 ? 2'd3 : s == 1 ? 2'd0 : 2'($urandom_range(0, 3)));
            write_reg(CFG_MERGE_BLANK,
                      s == 0 ? 2'd3 : s == 1 ? 2'd0 : 2'($urandom_range(0, 3)));
            write_reg(CFG_SHOW_ENDS,
                      s == 0 ? 2'd3 : s == 1 ? 2'd0 : 2'($urandom_range(0, 3)));
            write_reg(CFG_SHOW_TABS,
                      s == 0 ? 2'd3 : s == 1 ? 2'd0 : 2'($urandom_range(0, 3)));
            write_reg(CFG_SHOW_CTRL,
                      s == 0 ? 2'd3 : s == 1 ? 2'd0 : 2'($urandom_range(0, 3)));
            write_reg(3'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                      2'($urandom_range(0, 3)));
            settings_used++;
            for (int k = 0; k < SEG_WORDS; k++)
                send_word(pick_text_byte(), 1'b0, "");
        end

        in_valid <= 1'b0;
        while (rendered_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Fed %0d text bytes under %0d register settings, %0d rendered words checked",
                 bytes_sent, settings_used, words_checked);
        $display("Mixed sender gaps and receiver stalls in both proportions, then full rate");
        if (fail_count == 0 && rendered_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tlnc_pkg.sv
sv/tlnc_count.sv
sv/tlnc_expand.sv
sv/tlnc_drain.sv
sv/text_line_number_caret_filter.sv
tb/sv/text_line_number_caret_filter_tb.sv
